@@ design/ntcvt_pkg.sv @@
`timescale 1ns / 1ps

package ntcvt_pkg;

    // Voltage limit of the divider: 2.5 V in Q2.16.
    localparam logic [17:0] V_LIMIT     = 18'd163840;
    // 10 kOhm times 4096 for the Q7.12 resistance result.
    localparam logic [15:0] VOLT_SCALE  = 16'd40960;
    // Saturation value and inclusive window of the resistance, Q7.12 kOhm.
    localparam logic [18:0] R_MAX       = 19'd524287;
    localparam logic [18:0] R_LOW       = 19'd8839;
    localparam logic [18:0] R_HIGH      = 19'd301466;
    // Table index of 0 C.
    localparam int          TEMP_OFFSET = 20;
    // Fallback temperature 70.0 C in Q8.8.
    localparam logic [15:0] FALLBACK    = 16'd17920;

    // Shared divider geometry.
    localparam int          DIV_W       = 33;
    localparam int          REM_W       = 20;
    localparam logic [5:0]  DIV_R_STEPS = 6'd33;
    localparam logic [5:0]  DIV_Q_STEPS = 6'd29;

    localparam int          ROM_LISTED  = 100;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_DIV_R,
        ST_RCHK,
        ST_SEARCH,
        ST_CMP,
        ST_RD_HI,
        ST_RD_LO,
        ST_DIV_Q,
        ST_DONE
    } state_t;

    // Resistance in Q7.12 kOhm for -20 C up to 79 C in steps of 1 degree.
    localparam logic [19:0] ROM_TABLE [0:ROM_LISTED-1] = '{
        20'd286843, 20'd273039, 20'd259973, 20'd247603, 20'd235930,
        20'd224829, 20'd214344, 20'd204390, 20'd194970, 20'd186040,
        20'd177562, 20'd169492, 20'd161874, 20'd154624, 20'd147743,
        20'd141230, 20'd135004, 20'd129516, 20'd123535, 20'd118170,
        20'd113132, 20'd108298, 20'd103711, 20'd99328,  20'd95150,
        20'd91218,  20'd87409,  20'd83804,  20'd80404,  20'd77128,
        20'd74015,  20'd71025,  20'd68198,  20'd65454,  20'd62874,
        20'd60416,  20'd58040,  20'd55788,  20'd53617,  20'd51569,
        20'd49603,  20'd47718,  20'd45916,  20'd44196,  20'd42557,
        20'd40960,  20'd39449,  20'd37999,  20'd36610,  20'd35279,
        20'd34005,  20'd32784,  20'd31613,  20'd30491,  20'd29409,
        20'd28377,  20'd27386,  20'd26436,  20'd25518,  20'd24642,
        20'd23798,  20'd22991,  20'd22213,  20'd21463,  20'd20746,
        20'd20058,  20'd19390,  20'd18751,  20'd18141,  20'd17547,
        20'd16978,  20'd16433,  20'd15700,  20'd15397,  20'd14909,
        20'd14438,  20'd13988,  20'd13550,  20'd13128,  20'd12722,
        20'd12333,  20'd11956,  20'd11592,  20'd11239,  20'd10904,
        20'd10576,  20'd10260,  20'd9957,   20'd9662,   20'd9380,
        20'd9105,   20'd8839,   20'd8585,   20'd8339,   20'd8102,
        20'd7868,   20'd7647,   20'd7430,   20'd7225,   20'd7021
    };

    // Entries past the listed values read as zero.
    function automatic logic [19:0] rom_value(input logic [7:0] idx);
        logic [19:0] val;
        if (idx < 8'(ROM_LISTED))
        begin
            val = ROM_TABLE[idx[6:0]];
        end
        else
        begin
            val = 20'd0;
        end
        return val;
    endfunction

endpackage

@@ design/ntc_voltage_to_temperature_core.sv @@
`timescale 1ns / 1ps

// Channel    | Dir | Signals                    | Content
// -----------+-----+----------------------------+----------------------------------
// s (input)  | in  | s_tvalid s_tready s_tdata  | divider_voltage, Q2.16 V
// m (result) | out | m_tvalid m_tready m_tdata  | temperature, signed Q8.8 C
//            |     | m_tuser                    | in_range flag
//
// After reset the core copies the resistance table into its RAM, with s_tready
// low. An in-range item passes through the transfer, the resistance division, a
// window check, the search steps (six or seven for the default table), the
// fetch of the interval bounds, the fraction division and the loading of the
// result. A voltage of 2.5 V or more goes straight to the result, a resistance
// outside the window right after the window check. One item is in flight at a
// time; a waiting result lets the next transfer in, and the core holds its last
// step until the result register is free.

module ntc_voltage_to_temperature_core
    import ntcvt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 100
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] divider_voltage, [23:18] zero
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] temperature
    output logic [0:0]  m_tuser    // [0] in_range
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] dvs_reg, dvs_next;
    logic [18:0]      r_reg, r_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [IDX_W-1:0] hi_reg, hi_next;
    logic [19:0]      hi_val_reg, hi_val_next;
    logic             neg_reg, neg_next;
    logic             inr_reg, inr_next;
    logic [15:0]      out_temp_reg, out_temp_next;
    logic             out_flag_reg, out_flag_next;

    // RAM ports.
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [19:0]      ram_wr_data;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [19:0]      ram_rd_data;

    // Shared decision terms.
    logic [17:0]      volt;
    logic             accept;
    logic             volt_over;
    logic             fill_last;
    logic             div_last;
    logic [18:0]      r_sat;
    logic             r_outside;
    logic [IDX_W:0]   idx_sum;
    logic [IDX_W-1:0] mid;
    logic             search_done;
    logic             out_free;

    // Divider step.
    logic [REM_W:0]   rem_sh;
    logic             div_ge;
    logic [REM_W:0]   rem_sub;

    // Interpolation terms.
    logic [20:0]      den;
    logic             den_pos;
    logic [20:0]      diff;
    logic [20:0]      diff_mag;
    logic [28:0]      frac_num;
    logic signed [31:0] base_t;
    logic signed [31:0] temp_wide;
    logic [15:0]      temp_sat;

    assign volt      = s_tdata[17:0];
    assign accept    = s_tvalid && s_tready;
    assign volt_over = (volt >= V_LIMIT);
    assign fill_last = (fill_cnt_reg == CNT_W'(TABLE_ENTRIES - 1));
    assign div_last  = (cnt_reg == 6'd1);
    assign out_free  = !out_valid_reg || m_tready;

    // The quotient saturates to 19 bits before the window test.
    assign r_sat     = (|dvd_reg[DIV_W-1:19]) ? R_MAX : dvd_reg[18:0];
    assign r_outside = (r_sat < R_LOW) || (r_sat > R_HIGH);

    assign idx_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid         = idx_sum[IDX_W:1];
    assign search_done = ({1'b0, hi_reg} == ({1'b0, lo_reg} + 1'b1));

    // Restoring division, one quotient bit per cycle. Quotient bits enter
    // the dividend register from the bottom as its bits leave the top.
    assign rem_sh  = {rem_reg, dvd_reg[DIV_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    // Interval width and the distance of r from the lower-resistance bound.
    assign den      = {1'b0, ram_rd_data} - {1'b0, hi_val_reg};
    assign den_pos  = !den[20] && (den != 21'd0);
    assign diff     = {2'b00, r_reg} - {1'b0, hi_val_reg};
    assign diff_mag = diff[20] ? (21'd0 - diff) : diff;
    // Magnitude times 256 plus half the divisor rounds halves away from zero.
    assign frac_num = {diff_mag, 8'd0} + 29'(den[19:1]);

    // Final temperature: (hi - 20) * 256 minus the signed fraction.
    assign base_t    = (32'(signed'({1'b0, hi_reg})) - 32'(TEMP_OFFSET)) <<< 8;
    assign temp_wide = neg_reg ? (base_t + signed'({3'b000, dvd_reg[28:0]}))
                               : (base_t - signed'({3'b000, dvd_reg[28:0]}));
    always_comb
    begin
        if (temp_wide > 32'sd32767)
        begin
            temp_sat = 16'h7FFF;
        end
        else if (temp_wide < -32'sd32768)
        begin
            temp_sat = 16'h8000;
        end
        else
        begin
            temp_sat = temp_wide[15:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = volt_over ? ST_DONE : ST_DIV_R;
                end
            end
            ST_DIV_R:
            begin
                if (div_last)
                begin
                    state_next = ST_RCHK;
                end
            end
            ST_RCHK:
            begin
                state_next = r_outside ? ST_DONE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                state_next = search_done ? ST_RD_HI : ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_SEARCH;
            end
            ST_RD_HI:
            begin
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                state_next = den_pos ? ST_DIV_Q : ST_DONE;
            end
            ST_DIV_Q:
            begin
                if (div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        s_tready       = 1'b0;
        fill_cnt_next  = fill_cnt_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        hi_val_next    = hi_val_reg;
        neg_next       = neg_reg;
        inr_next       = inr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_temp_next  = out_temp_reg;
        out_flag_next  = out_flag_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = fill_cnt_reg[IDX_W-1:0];
        ram_wr_data    = rom_value(8'(fill_cnt_reg[IDX_W-1:0]));
        ram_rd_addr    = hi_reg;

        unique case (state_reg)
            ST_FILL:
            begin
                ram_wr_en     = 1'b1;
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    inr_next = 1'b0;
                    dvd_next = DIV_W'(volt) * DIV_W'(VOLT_SCALE);
                    rem_next = '0;
                    dvs_next = REM_W'(V_LIMIT - volt);
                    cnt_next = DIV_R_STEPS;
                end
            end
            ST_DIV_R, ST_DIV_Q:
            begin
                dvd_next = {dvd_reg[DIV_W-2:0], div_ge};
                rem_next = div_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                cnt_next = cnt_reg - 1'b1;
            end
            ST_RCHK:
            begin
                if (!r_outside)
                begin
                    r_next   = r_sat;
                    lo_next  = '0;
                    hi_next  = LAST_IDX;
                    inr_next = 1'b1;
                end
            end
            ST_SEARCH:
            begin
                ram_rd_addr = search_done ? hi_reg : mid;
            end
            ST_CMP:
            begin
                if (ram_rd_data > {1'b0, r_reg})
                begin
                    lo_next = mid;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            ST_RD_HI:
            begin
                hi_val_next = ram_rd_data;
                ram_rd_addr = lo_reg;
            end
            ST_RD_LO:
            begin
                neg_next = diff[20];
                rem_next = '0;
                dvs_next = den[19:0];
                cnt_next = DIV_Q_STEPS;
                if (den_pos)
                begin
                    dvd_next = {frac_num, 4'd0};
                end
                else
                begin
                    dvd_next = '0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = inr_reg;
                    out_temp_next  = inr_reg ? temp_sat : FALLBACK;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_cnt_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        r_reg        <= r_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        hi_val_reg   <= hi_val_next;
        neg_reg      <= neg_next;
        inr_reg      <= inr_next;
        out_temp_reg <= out_temp_next;
        out_flag_reg <= out_flag_next;
    end

    ntcvt_ram #(
        .WIDTH (20),
        .DEPTH (TABLE_ENTRIES)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_temp_reg;
    assign m_tuser  = out_flag_reg;

endmodule

@@ design/ntcvt_ram.sv @@
`timescale 1ns / 1ps

module ntcvt_ram #(
    parameter int WIDTH  = 20,
    parameter int DEPTH  = 100,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/ntcvt_checker.sv @@
`timescale 1ns / 1ps

module ntcvt_checker
    import ntcvt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An out-of-range result carries the fallback temperature.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == FALLBACK)
        else $error("out-of-range result without fallback value");

    // One item at a time: the core is busy right after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // A new result is only produced while the core was busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in flight");

endmodule

bind ntc_voltage_to_temperature_core ntcvt_checker u_checker (.*);

@@ verif/ntc_voltage_to_temperature_core_test.sv @@
`timescale 1ns / 1ps

module ntc_voltage_to_temperature_core_test;

    // Own copy of the thermistor table: resistance in Q7.12 kOhm from -20 C up
    // to 79 C in steps of one degree, strictly descending.
    localparam int ENTRIES = 100;
    localparam logic [19:0] OHM_TABLE [0:ENTRIES-1] = '{
        20'd286843, 20'd273039, 20'd259973, 20'd247603, 20'd235930,
        20'd224829, 20'd214344, 20'd204390, 20'd194970, 20'd186040,
        20'd177562, 20'd169492, 20'd161874, 20'd154624, 20'd147743,
        20'd141230, 20'd135004, 20'd129516, 20'd123535, 20'd118170,
        20'd113132, 20'd108298, 20'd103711, 20'd99328,  20'd95150,
        20'd91218,  20'd87409,  20'd83804,  20'd80404,  20'd77128,
        20'd74015,  20'd71025,  20'd68198,  20'd65454,  20'd62874,
        20'd60416,  20'd58040,  20'd55788,  20'd53617,  20'd51569,
        20'd49603,  20'd47718,  20'd45916,  20'd44196,  20'd42557,
        20'd40960,  20'd39449,  20'd37999,  20'd36610,  20'd35279,
        20'd34005,  20'd32784,  20'd31613,  20'd30491,  20'd29409,
        20'd28377,  20'd27386,  20'd26436,  20'd25518,  20'd24642,
        20'd23798,  20'd22991,  20'd22213,  20'd21463,  20'd20746,
        20'd20058,  20'd19390,  20'd18751,  20'd18141,  20'd17547,
        20'd16978,  20'd16433,  20'd15700,  20'd15397,  20'd14909,
        20'd14438,  20'd13988,  20'd13550,  20'd13128,  20'd12722,
        20'd12333,  20'd11956,  20'd11592,  20'd11239,  20'd10904,
        20'd10576,  20'd10260,  20'd9957,   20'd9662,   20'd9380,
        20'd9105,   20'd8839,   20'd8585,   20'd8339,   20'd8102,
        20'd7868,   20'd7647,   20'd7430,   20'd7225,   20'd7021
    };

    // Divider limit of 2.5 V in Q2.16 and the 10 kOhm scale times 4096.
    localparam longint unsigned VOLT_LIMIT = 163840;
    localparam longint unsigned OHM_SCALE  = 40960;
    // Saturation value and inclusive table window, Q7.12 kOhm.
    localparam logic [18:0] OHM_SAT   = 19'd524287;
    localparam logic [18:0] OHM_FLOOR = 19'd8839;
    localparam logic [18:0] OHM_CEIL  = 19'd301466;
    // Table index of 0 C and the fallback temperature of 70.0 C in Q8.8.
    localparam int          ZERO_C_INDEX = 20;
    localparam logic [15:0] FALLBACK_TEMP = 16'd17920;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;

    // Tracks the temperature readings that the core owes, oldest first.
    class temp_scoreboard;
        typedef struct {
            logic signed [15:0] temperature;
            logic               in_range;
        } reading_t;

        reading_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Thermistor resistance for a divider voltage below 2.5 V, saturated.
        function logic [18:0] resistance_of(logic [17:0] volts);
            longint unsigned num;
            longint unsigned den;
            longint unsigned quo;
            num = longint'(volts) * OHM_SCALE;
            den = VOLT_LIMIT - longint'(volts);
            quo = num / den;
            return (quo > longint'(OHM_SAT)) ? OHM_SAT : quo[18:0];
        endfunction

        function reading_t convert(logic [17:0] volts);
            reading_t    res;
            logic [18:0] ohms;
            int          lo;
            int          hi;
            int          mid;
            longint      num;
            longint      den;
            longint      frac;
            longint      temp;
            res.temperature = FALLBACK_TEMP;
            res.in_range    = 1'b0;
            if (longint'(volts) >= VOLT_LIMIT)
            begin
                return res;
            end
            ohms = resistance_of(volts);
            if (ohms < OHM_FLOOR || ohms > OHM_CEIL)
            begin
                return res;
            end
            // Binary search for the interval with table[lo] > r >= table[hi].
            lo = 0;
            hi = ENTRIES - 1;
            while (hi != lo + 1)
            begin
                mid = (lo + hi) >> 1;
                if (longint'(OHM_TABLE[mid]) > longint'(ohms))
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid;
                end
            end
            num = (longint'(ohms) - longint'(OHM_TABLE[hi])) * 256;
            den = longint'(OHM_TABLE[lo]) - longint'(OHM_TABLE[hi]);
            // Round to nearest with halves away from zero; above the first
            // entry the fraction passes 256 and the result extrapolates.
            if (den <= 0)
            begin
                frac = 0;
            end
            else if (num >= 0)
            begin
                frac = (num + den / 2) / den;
            end
            else
            begin
                frac = -((-num + den / 2) / den);
            end
            temp = (longint'(hi) - ZERO_C_INDEX) * 256 - frac;
            if (temp > 32767)
            begin
                temp = 32767;
            end
            if (temp < -32768)
            begin
                temp = -32768;
            end
            res.temperature = temp[15:0];
            res.in_range    = 1'b1;
            return res;
        endfunction

        function void note_voltage(logic [17:0] volts);
            pending.push_back(convert(volts));
        endfunction

        function void check_reading(logic signed [15:0] temperature, logic in_range);
            reading_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected transfer: temperature %0d in_range %0b",
                       temperature, in_range);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (temperature !== want.temperature)
            begin
                $error("temperature mismatch: expected %0d, actual %0d",
                       want.temperature, temperature);
                errors++;
            end
            if (in_range !== want.in_range)
            begin
                $error("in_range mismatch: expected %0b, actual %0b",
                       want.in_range, in_range);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    temp_scoreboard sb;
    int             cycle_count = 0;
    // When set, the matching side runs without gaps for a stretch of items.
    bit             s_no_idle = 1'b0;
    bit             m_no_idle = 1'b0;

    ntc_voltage_to_temperature_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: the slowest correct run, including the table fill after
    // reset, stays far below this limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ntc_voltage_to_temperature_core_test NOT OK");
            $finish;
        end
    end

    // Smallest voltage whose resistance reaches the target. The resistance
    // grows monotonically with the voltage below 2.5 V, so a bisection works.
    function automatic logic [17:0] voltage_for(logic [18:0] target);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = int'(VOLT_LIMIT) - 1;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (sb.resistance_of(mid[17:0]) >= target)
            begin
                hi = mid;
            end
            else
            begin
                lo = mid + 1;
            end
        end
        return lo[17:0];
    endfunction

    // Random voltage, weighted so that most items land inside the table
    // window and exercise the search and interpolation.
    function automatic logic [17:0] draw_voltage();
        int pick;
        int base;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            base = $urandom_range(28000, 146000);
        end
        else if (pick < 70)
        begin
            // Close to an exact table entry, on either side of it.
            base = int'(voltage_for(OHM_TABLE[$urandom_range(0, ENTRIES - 1)]));
            base = base + int'($urandom_range(0, 6)) - 3;
        end
        else if (pick < 80)
        begin
            // Around the edges of the resistance window.
            if ($urandom_range(0, 1) == 1)
            begin
                base = int'(voltage_for(OHM_FLOOR));
            end
            else
            begin
                base = int'(voltage_for(OHM_CEIL + 19'd1));
            end
            base = base + int'($urandom_range(0, 8)) - 4;
        end
        else if (pick < 92)
        begin
            base = $urandom_range(0, 262143);
        end
        else
        begin
            // At or above 2.5 V, including the saturating region just below.
            base = $urandom_range(int'(VOLT_LIMIT) - 40, 262143);
        end
        if (base < 0)
        begin
            base = 0;
        end
        return base[17:0];
    endfunction

    // Drives one voltage transfer; called at a falling edge and returns at
    // the falling edge after the transfer has been accepted.
    task automatic send_voltage(input logic [17:0] volts);
        int gap;
        gap = s_no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, volts};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_voltage(volts);
        @(negedge clk);
    endtask

    // Accepts temperature readings forever, with a random hold-off before
    // each one, except while m_no_idle is set.
    task automatic receive_readings();
        int gap;
        int count;
        count = 0;
        forever
        begin
            if (count % 64 == 0)
            begin
                m_no_idle = ($urandom_range(0, 3) == 0);
            end
            gap = m_no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            sb.check_reading(m_tdata, m_tuser[0]);
            count++;
            @(negedge clk);
        end
    endtask

    // Edges of the voltage range and of the resistance window, exact table
    // entries, extrapolation above the first entry and the saturating region.
    task automatic run_directed();
        send_voltage(18'd0);
        send_voltage(18'd1);
        send_voltage(18'd163839);
        send_voltage(18'd163840);
        send_voltage(18'd163841);
        send_voltage(18'd262143);
        send_voltage(18'h15555);
        send_voltage(18'h2AAAA);
        send_voltage(voltage_for(OHM_FLOOR) - 18'd1);
        send_voltage(voltage_for(OHM_FLOOR));
        send_voltage(voltage_for(OHM_CEIL));
        send_voltage(voltage_for(OHM_CEIL + 19'd1) - 18'd1);
        send_voltage(voltage_for(OHM_CEIL + 19'd1));
        send_voltage(voltage_for(19'd286843));
        send_voltage(voltage_for(19'd286844));
        send_voltage(voltage_for(19'd273039));
        send_voltage(voltage_for(19'd113132));
        send_voltage(voltage_for(19'd40960));
        send_voltage(voltage_for(19'd15700));
        send_voltage(voltage_for(19'd15650));
        send_voltage(voltage_for(19'd9105) - 18'd1);
        send_voltage(voltage_for(19'd200000));
    endtask

    task automatic run_random();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
            begin
                s_no_idle = ($urandom_range(0, 3) == 0);
            end
            send_voltage(draw_voltage());
        end
    endtask

    initial
    begin
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 24'd0;
        m_tready = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        fork
            receive_readings();
        join_none
        // The core fills its table RAM first; send_voltage simply waits for
        // s_tready, so no extra delay is needed here.
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        // Give any stray transfer a chance to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("ntc_voltage_to_temperature_core_test OK");
        end
        else
        begin
            $display("ntc_voltage_to_temperature_core_test NOT OK");
        end
        $finish;
    end

endmodule
